// ===== sv/tbop_pkg.sv =====
// Shared types and constants for the timer bank.
package tbop_pkg;

  localparam int MAX_RESULTS = 8;
  localparam int EV_W        = $clog2(MAX_RESULTS + 1);
  localparam int PADDR_W     = 3;

  localparam logic [2:0] CMD_CREATE = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_DELETE = 3'd3;
  localparam logic [2:0] CMD_TICK   = 3'd4;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  localparam logic        REG_TICK_STEP   = 1'b0;
  localparam logic [15:0] TICK_STEP_RESET = 16'd100;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  slot;
    logic [31:0] interval;
    logic        periodic;
    logic        notify;
  } cmd_item_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] timer_slot;
    logic       ok;
    logic       last;
  } res_item_t;

  typedef struct packed {
    logic [31:0] period;
    logic        periodic;
    logic        notify;
  } cfg_entry_t;

endpackage

// ===== sv/tbop_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
module tbop_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/tbop_ctrl.sv =====
// Command sequencer: slot allocation, memory read-modify-write and result output.
module tbop_ctrl #(
  parameter int NUM_TIMERS = 8,
  parameter int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  tbop_pkg::cmd_item_t    cmd_data,
  output logic                   res_valid,
  input  logic                   res_stall,
  output tbop_pkg::res_item_t    res_data,
  input  logic [15:0]            tick_step,
  output logic                   cfg_we,
  output logic [IDX_W-1:0]       cfg_waddr,
  output tbop_pkg::cfg_entry_t   cfg_wdata,
  output logic                   cfg_re,
  output logic [IDX_W-1:0]       cfg_raddr,
  input  tbop_pkg::cfg_entry_t   cfg_rdata,
  output logic                   rem_we,
  output logic [IDX_W-1:0]       rem_waddr,
  output logic [31:0]            rem_wdata,
  output logic                   rem_re,
  output logic [IDX_W-1:0]       rem_raddr,
  input  logic [31:0]            rem_rdata
);
  import tbop_pkg::*;

  localparam int SW = (IDX_W > 3) ? IDX_W + 1 : 4;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_START, S_WALK, S_FLUSH} state_t;

  state_t                  state;
  cmd_item_t               cmd_q;
  logic [NUM_TIMERS-1:0]   used;
  logic [IDX_W-1:0]        idx;
  logic [EV_W-1:0]         n_ev;
  logic                    pend_valid;
  logic [2:0]              pend_slot;

  logic [SW-1:0]           slot_wide;
  logic [IDX_W-1:0]        slot_ix;
  logic                    slot_ok;
  logic [IDX_W-1:0]        free_ix;
  logic                    free_found;
  logic                    out_free;
  logic                    active;
  logic                    expire;
  logic                    want_ev;
  logic                    walk_hold;
  logic                    last_slot;
  logic                    res_load;

  assign cmd_stall = (state != S_IDLE);
  assign out_free  = !res_valid || !res_stall;

  assign slot_wide = SW'(cmd_q.slot);
  assign slot_ix   = slot_wide[IDX_W-1:0];
  assign slot_ok   = (slot_wide < SW'(NUM_TIMERS)) && used[slot_ix];

  always_comb begin
    free_ix    = '0;
    free_found = 1'b0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_ix    = IDX_W'(i);
        free_found = 1'b1;
      end
    end
  end

  assign active    = used[idx] && (rem_rdata != 32'd0);
  assign expire    = active && (rem_rdata <= {16'd0, tick_step});
  assign want_ev   = expire && cfg_rdata.notify && (n_ev < EV_W'(MAX_RESULTS));
  assign walk_hold = want_ev && pend_valid && !out_free;
  assign last_slot = (idx == IDX_W'(NUM_TIMERS - 1));

  assign res_load = ((state == S_EXEC) && (cmd_q.cmd == CMD_CREATE) && out_free) ||
                    ((state == S_WALK) && !walk_hold && want_ev && pend_valid) ||
                    ((state == S_FLUSH) && pend_valid && out_free);

  always_comb begin
    cfg_we    = 1'b0;
    cfg_waddr = '0;
    cfg_wdata = '{period: cmd_q.interval, periodic: cmd_q.periodic, notify: cmd_q.notify};
    cfg_re    = 1'b0;
    cfg_raddr = '0;
    rem_we    = 1'b0;
    rem_waddr = '0;
    rem_wdata = cmd_q.interval;
    rem_re    = 1'b0;
    rem_raddr = '0;
    case (state)
      S_EXEC: begin
        case (cmd_q.cmd)
          CMD_CREATE: begin
            if (out_free && free_found) begin
              cfg_we    = 1'b1;
              cfg_waddr = free_ix;
              rem_we    = 1'b1;
              rem_waddr = free_ix;
            end
          end
          CMD_START: begin
            if (slot_ok) begin
              cfg_re    = 1'b1;
              cfg_raddr = slot_ix;
            end
          end
          CMD_STOP: begin
            if (slot_ok) begin
              rem_we    = 1'b1;
              rem_waddr = slot_ix;
              rem_wdata = 32'd0;
            end
          end
          CMD_TICK: begin
            cfg_re = 1'b1;
            rem_re = 1'b1;
          end
          default: ;
        endcase
      end
      S_START: begin
        rem_we    = 1'b1;
        rem_waddr = slot_ix;
        rem_wdata = cfg_rdata.period;
      end
      S_WALK: begin
        if (!walk_hold) begin
          rem_waddr = idx;
          if (expire) begin
            rem_wdata = cfg_rdata.periodic ? cfg_rdata.period : 32'd0;
          end else begin
            rem_wdata = rem_rdata - {16'd0, tick_step};
          end
          rem_we = active;
          if (!last_slot) begin
            cfg_re    = 1'b1;
            rem_re    = 1'b1;
            cfg_raddr = idx + 1'b1;
            rem_raddr = idx + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      res_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_q <= cmd_data;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cmd_q.cmd)
            CMD_CREATE: begin
              if (out_free) begin
                res_data  <= '{kind: KIND_REPLY,
                               timer_slot: free_found ? 3'(free_ix) : 3'd0,
                               ok: free_found, last: 1'b1};
                if (free_found) begin
                  used[free_ix] <= 1'b1;
                end
                state <= S_IDLE;
              end
            end
            CMD_START: begin
              state <= slot_ok ? S_START : S_IDLE;
            end
            CMD_DELETE: begin
              if (slot_ok) begin
                used[slot_ix] <= 1'b0;
              end
              state <= S_IDLE;
            end
            CMD_TICK: begin
              idx   <= '0;
              n_ev  <= '0;
              state <= S_WALK;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_START: begin
          state <= S_IDLE;
        end
        S_WALK: begin
          if (!walk_hold) begin
            if (want_ev) begin
              if (pend_valid) begin
                res_data  <= '{kind: KIND_EVENT, timer_slot: pend_slot, ok: 1'b1, last: 1'b0};
              end
              pend_valid <= 1'b1;
              pend_slot  <= 3'(idx);
              n_ev       <= EV_W'(n_ev + 1'b1);
            end
            if (last_slot) begin
              state <= S_FLUSH;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            res_data   <= '{kind: KIND_EVENT, timer_slot: pend_slot, ok: 1'b1, last: 1'b1};
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/timer_bank_oneshot_periodic.sv =====
// Top level of the timer bank: register port, slot memories and sequencer.
//
//   channel  dir  handshake            payload
//   cmd      in   cmd_valid/cmd_stall  cmd_data   (tbop_pkg::cmd_item_t)
//   res      out  res_valid/res_stall  res_data   (tbop_pkg::res_item_t)
//   apb      in   psel/penable/pready  paddr, pwdata, prdata
//
// One command at a time. Start reads the period in S_EXEC, then writes the remaining count in S_START.
// A tick walks the slot memories one slot per cycle whenever the walk is not held.
// A stalled result holds the walk only when a second event is waiting.
// Synchronous reset frees every slot; no memory clearing pass is needed.
module timer_bank_oneshot_periodic #(
  parameter int NUM_TIMERS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  tbop_pkg::cmd_item_t             cmd_data,
  output logic                            res_valid,
  input  logic                            res_stall,
  output tbop_pkg::res_item_t             res_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tbop_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import tbop_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  logic [15:0]      tick_step;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_waddr;
  cfg_entry_t       cfg_wdata;
  logic             cfg_re;
  logic [IDX_W-1:0] cfg_raddr;
  cfg_entry_t       cfg_rdata;
  logic             rem_we;
  logic [IDX_W-1:0] rem_waddr;
  logic [31:0]      rem_wdata;
  logic             rem_re;
  logic [IDX_W-1:0] rem_raddr;
  logic [31:0]      rem_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TICK_STEP) ? {16'd0, tick_step} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= TICK_STEP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TICK_STEP)) begin
      tick_step <= pwdata[15:0];
    end
  end

  tbop_ctrl #(
    .NUM_TIMERS (NUM_TIMERS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .tick_step (tick_step),
    .cfg_we    (cfg_we),
    .cfg_waddr (cfg_waddr),
    .cfg_wdata (cfg_wdata),
    .cfg_re    (cfg_re),
    .cfg_raddr (cfg_raddr),
    .cfg_rdata (cfg_rdata),
    .rem_we    (rem_we),
    .rem_waddr (rem_waddr),
    .rem_wdata (rem_wdata),
    .rem_re    (rem_re),
    .rem_raddr (rem_raddr),
    .rem_rdata (rem_rdata)
  );

  tbop_ram #(
    .WIDTH ($bits(cfg_entry_t)),
    .DEPTH (NUM_TIMERS),
    .AW    (IDX_W)
  ) u_cfg_ram (
    .clk   (clk),
    .we    (cfg_we),
    .waddr (cfg_waddr),
    .wdata (cfg_wdata),
    .re    (cfg_re),
    .raddr (cfg_raddr),
    .rdata (cfg_rdata)
  );

  tbop_ram #(
    .WIDTH (32),
    .DEPTH (NUM_TIMERS),
    .AW    (IDX_W)
  ) u_rem_ram (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .re    (rem_re),
    .raddr (rem_raddr),
    .rdata (rem_rdata)
  );

endmodule

// ===== sv/tbop_chk.sv =====
// Port-level checker for the timer bank, bound to the top level.
module tbop_chk (
  input logic                clk,
  input logic                rst,
  input logic                cmd_valid,
  input logic                cmd_stall,
  input logic                res_valid,
  input logic                res_stall,
  input tbop_pkg::res_item_t res_data
);
  import tbop_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("second command taken while one is in flight");

  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.kind == KIND_REPLY) |-> res_data.last)
    else $error("create reply not marked last");

  a_event_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.kind == KIND_EVENT) |-> res_data.ok)
    else $error("expiry event without ok");

  a_full_slot: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.kind == KIND_REPLY) && !res_data.ok |-> res_data.timer_slot == 3'd0)
    else $error("failed create reply carries a slot");

endmodule

bind timer_bank_oneshot_periodic tbop_chk u_chk (.*);
